@@ rtl/pearson_normalize_sparse_filter_unit_assert.svh @@
// Assertion macros for the checker file of the correlation unit.
// Depends on nothing; include by bare file name.
`ifndef PEARSON_NORMALIZE_SPARSE_FILTER_UNIT_ASSERT_SVH
`define PEARSON_NORMALIZE_SPARSE_FILTER_UNIT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define PNSF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PNSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/pnsf_pkg.sv @@
// Shared types and constants for the Pearson correlation unit.
// Depends on nothing.
package pnsf_pkg;
  localparam int MaxSources = 65536;
  localparam int CountW = 17;
  localparam int QW = 17;
  localparam int NumW = 88;
  localparam int DenW = 88;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = 2;

  localparam logic [2:0] RegObs = 3'd0;
  localparam logic [2:0] RegKeepNeg = 3'd1;
  localparam logic [2:0] RegClrMiss = 3'd2;
  localparam logic [2:0] RegClrInf = 3'd3;
  localparam logic [2:0] RegMinMag = 3'd4;

  localparam logic [17:0] OneQ = 18'sd65536;

  // Item as classified by the front part.
  typedef struct packed {
    logic [15:0]     row;
    logic            neg;
    logic [NumW-1:0] mag;
    logic [DenW-1:0] den;
    logic            last;
  } work_t;

  typedef struct packed {
    logic        keep_negative;
    logic        clear_missing;
    logic        clear_infinite;
    logic [16:0] min_magnitude;
  } cfg_t;
endpackage

@@ rtl/pearson_normalize_sparse_filter_unit.sv @@
// Channel  | direction | handshake
// items    | in        | push / full
// results  | out       | pop / empty
// config   | in        | APB write, pready tied high
// A cell passes through the multiply front and then the back (load, 16 divide
// steps, finish); its result shows after the finish step.
// The back holds one cell until its result is popped and takes no new one before.
// The four-entry queue lets the front keep accepting while the back works.
// Reset is synchronous, active high, and restores register defaults.
// Top level of the correlation unit; depends on pnsf_pkg and submodules.
module pearson_normalize_sparse_filter_unit (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic push,
  output logic full,
  input  logic [15:0] source_index,
  input  logic signed [47:0] cross_prod,
  input  logic signed [31:0] source_mean,
  input  logic [31:0] source_sd,
  input  logic signed [31:0] dest_mean,
  input  logic [31:0] dest_sd,
  input  logic column_last,
  output logic empty,
  input  logic pop,
  output logic [15:0] row_out,
  output logic signed [17:0] correlation,
  output logic emit,
  output logic is_missing,
  output logic is_infinite,
  output logic column_done,
  output logic [16:0] column_count
);
  import pnsf_pkg::*;
  logic [23:0] obs;
  cfg_t cfg;
  logic [2:0] idx;
  logic fv, fr, qv, qr;
  work_t fw, qw;
  logic [23:0] n_eff;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign n_eff = obs < 24'd2 ? 24'd2 : obs;

  always_ff @(posedge clk) begin
    if (rst) begin
      obs <= 24'd2;
      cfg <= '{keep_negative: 1'b1, clear_missing: 1'b0, clear_infinite: 1'b0,
               min_magnitude: 17'd0};
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegObs: obs <= pwdata[23:0];
        RegKeepNeg: cfg.keep_negative <= pwdata[0];
        RegClrMiss: cfg.clear_missing <= pwdata[0];
        RegClrInf: cfg.clear_infinite <= pwdata[0];
        RegMinMag: cfg.min_magnitude <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegObs: prdata = {8'd0, obs};
      RegKeepNeg: prdata = {31'd0, cfg.keep_negative};
      RegClrMiss: prdata = {31'd0, cfg.clear_missing};
      RegClrInf: prdata = {31'd0, cfg.clear_infinite};
      RegMinMag: prdata = {15'd0, cfg.min_magnitude};
      default: prdata = '0;
    endcase
  end

  logic in_ready;
  assign full = !in_ready;

  pnsf_front u_front (
    .clk, .rst, .in_valid(push), .in_ready, .source_index, .cross_prod,
    .source_mean, .source_sd, .dest_mean, .dest_sd, .column_last, .n_eff,
    .out_valid(fv), .out_ready(fr), .out_work(fw)
  );
  pnsf_queue u_queue (
    .clk, .rst, .in_valid(fv), .in_ready(fr), .in_work(fw),
    .out_valid(qv), .out_ready(qr), .out_work(qw)
  );
  pnsf_back u_back (
    .clk, .rst, .in_valid(qv), .in_ready(qr), .in_work(qw), .cfg, .empty, .pop,
    .row_out, .correlation, .emit, .is_missing, .is_infinite, .column_done,
    .column_count
  );
endmodule

@@ rtl/pnsf_front.sv @@
// Front part: multiplies out numerator and denominator over three stages.
// Depends on pnsf_pkg.
module pnsf_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [15:0] source_index,
  input  logic signed [47:0] cross_prod,
  input  logic signed [31:0] source_mean,
  input  logic [31:0] source_sd,
  input  logic signed [31:0] dest_mean,
  input  logic [31:0] dest_sd,
  input  logic column_last,
  input  logic [23:0] n_eff,
  output logic out_valid,
  input  logic out_ready,
  output pnsf_pkg::work_t out_work
);
  import pnsf_pkg::*;

  // Stage 1: magnitudes products mx*my and sx*sy.
  logic        v1, v2, v3;
  logic [15:0] row1, row2, row3;
  logic        last1, last2, last3;
  logic        cpn1, pn1, cpn2, pn2, cpn3, pn3;
  logic [47:0] cpm1, cpm2, cpm3;
  logic [63:0] pm1, ps1;
  logic [23:0] n1, n2;
  logic [87:0] b2, b3, d2, d3;
  logic [31:0] mxm, mym;
  logic [47:0] cpm;
  logic        stall;

  assign stall = v3 && !out_ready;
  assign in_ready = !stall;
  assign mxm = source_mean[31] ? 32'(-source_mean) : source_mean;
  assign mym = dest_mean[31] ? 32'(-dest_mean) : dest_mean;
  assign cpm = cross_prod[47] ? 48'(-cross_prod) : cross_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (!stall) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 2 multiplies each 64-bit product by the 24-bit count (the sd product by the
  // count minus one) as two 32x24 parts that are summed into the register.
  logic [55:0] bl, bh, dl, dh;
  assign bl = pm1[31:0] * n1;
  assign bh = pm1[63:32] * n1;
  assign dl = ps1[31:0] * (n1 - 24'd1);
  assign dh = ps1[63:32] * (n1 - 24'd1);

  logic [87:0] numa;
  logic [87:0] numb;
  logic [88:0] numd;
  assign numa = {24'd0, cpm3, 16'd0};
  assign numb = b3;
  always_comb begin
    logic signed [88:0] sa, sb;
    sa = cpn3 ? -$signed({1'b0, numa}) : $signed({1'b0, numa});
    sb = pn3 ? -$signed({1'b0, numb}) : $signed({1'b0, numb});
    numd = 89'(sa - sb);
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      row1 <= source_index;
      last1 <= column_last;
      cpn1 <= cross_prod[47];
      pn1 <= source_mean[31] ^ dest_mean[31];
      cpm1 <= cpm;
      pm1 <= mxm * mym;
      ps1 <= source_sd * dest_sd;
      n1 <= n_eff;
      row2 <= row1;
      last2 <= last1;
      cpn2 <= cpn1;
      pn2 <= pn1;
      cpm2 <= cpm1;
      b2 <= {32'd0, bl} + {bh, 32'd0};
      d2 <= {32'd0, dl} + {dh, 32'd0};
      row3 <= row2;
      last3 <= last2;
      cpn3 <= cpn2;
      pn3 <= pn2;
      cpm3 <= cpm2;
      b3 <= b2;
      d3 <= d2;
    end
  end

  logic [88:0] numm;
  assign numm = numd[88] ? 89'(-numd) : numd;
  assign out_valid = v3;
  assign out_work.row = row3;
  assign out_work.last = last3;
  assign out_work.neg = numd[88];
  assign out_work.mag = numm[NumW-1:0];
  assign out_work.den = d3;
  logic unused;
  assign unused = ^{n2, numm[88:NumW]};
  always_ff @(posedge clk) n2 <= n1;
endmodule

@@ rtl/pnsf_queue.sv @@
// Short queue between the front and back parts.
// Depends on pnsf_pkg.
module pnsf_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  pnsf_pkg::work_t in_work,
  output logic out_valid,
  input  logic out_ready,
  output pnsf_pkg::work_t out_work
);
  import pnsf_pkg::*;
  work_t mem [QueueDepth];
  logic [QueuePtrW-1:0] wp, rp;
  logic [QueuePtrW:0] cnt;
  logic wr, rd;
  assign in_ready = cnt != 3'(QueueDepth);
  assign out_valid = cnt != '0;
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;
  assign out_work = mem[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + {2'd0, wr} - {2'd0, rd};
    end
  end
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= in_work;
  end
endmodule

@@ rtl/pnsf_back.sv @@
// Back part: 16-step restoring divide, clearing rules and column count.
// Depends on pnsf_pkg.
module pnsf_back (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  pnsf_pkg::work_t in_work,
  input  pnsf_pkg::cfg_t cfg,
  output logic empty,
  input  logic pop,
  output logic [15:0] row_out,
  output logic signed [17:0] correlation,
  output logic emit,
  output logic is_missing,
  output logic is_infinite,
  output logic column_done,
  output logic [16:0] column_count
);
  import pnsf_pkg::*;
  typedef enum logic [1:0] {Idle, Divide, Finish, Hold} state_t;
  state_t state;
  work_t w;
  logic [DenW:0] rem;
  logic [4:0] step;
  logic [15:0] q;
  logic [16:0] emitted;
  logic [DenW:0] sh;
  logic [17:0] val;
  logic [16:0] qf, mag;
  logic miss, inf, em;

  assign sh = {rem[DenW-1:0], 1'b0};
  assign in_ready = state == Idle;
  assign empty = state != Hold;

  always_comb begin
    miss = 1'b0;
    inf = 1'b0;
    if (w.den == '0) begin
      miss = w.mag == '0;
      inf = !miss;
      qf = miss ? 17'd0 : 17'd65536;
    end else if (w.mag >= w.den) begin
      qf = 17'd65536;
    end else begin
      qf = {1'b0, q};
    end
    val = w.neg ? 18'(-{1'b0, qf}) : {1'b0, qf};
    if (cfg.clear_missing && miss) miss = 1'b0;
    if (cfg.clear_infinite && inf) begin
      val = '0;
      inf = 1'b0;
    end
    if (!cfg.keep_negative && !miss && val[17]) begin
      val = '0;
      inf = 1'b0;
    end
    mag = val[17] ? 17'(-val) : val[16:0];
    if (cfg.min_magnitude != '0 && !miss && mag < cfg.min_magnitude) begin
      val = '0;
      inf = 1'b0;
    end
    em = miss || val != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle;
      emitted <= '0;
    end else begin
      case (state)
        Idle: begin
          if (in_valid) begin
            w <= in_work;
            rem <= {1'b0, in_work.mag};
            q <= '0;
            step <= '0;
            state <= Divide;
          end
        end
        Divide: begin
          if (sh >= {1'b0, w.den}) begin
            rem <= sh - {1'b0, w.den};
            q <= {q[14:0], 1'b1};
          end else begin
            rem <= sh;
            q <= {q[14:0], 1'b0};
          end
          step <= step + 5'd1;
          if (step == 5'd15) state <= Finish;
        end
        Finish: begin
          row_out <= w.row;
          correlation <= val;
          emit <= em;
          is_missing <= miss;
          is_infinite <= inf;
          column_done <= w.last;
          if (w.last) begin
            column_count <= (em && emitted < 17'(MaxSources)) ? emitted + 17'd1 : emitted;
            emitted <= '0;
          end else begin
            column_count <= '0;
            if (em && emitted < 17'(MaxSources)) emitted <= emitted + 17'd1;
          end
          state <= Hold;
        end
        Hold: begin
          if (pop) state <= Idle;
        end
        default: state <= Idle;
      endcase
    end
  end
endmodule

@@ rtl/pnsf_checker.sv @@
// Port-level checker for the correlation unit, bound to the top level.
// Depends on pearson_normalize_sparse_filter_unit_assert.svh.
`include "pearson_normalize_sparse_filter_unit_assert.svh"
module pnsf_checker (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input logic emit,
  input logic is_missing,
  input logic is_infinite,
  input logic column_done,
  input logic [16:0] column_count,
  input logic signed [17:0] correlation
);
  `PNSF_ASSERT_IMPL(a_miss_zero, clk, rst, !empty && is_missing, correlation == 18'sd0)
  `PNSF_ASSERT_IMPL(a_emit_def, clk, rst, !empty, emit == (is_missing || correlation != 0))
  `PNSF_ASSERT_IMPL(a_flags, clk, rst, !empty, !(is_missing && is_infinite))
  `PNSF_ASSERT_IMPL(a_count, clk, rst, !empty && !column_done, column_count == 17'd0)
  `PNSF_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty)
endmodule

bind pearson_normalize_sparse_filter_unit pnsf_checker u_checker (
  .clk, .rst, .empty, .pop, .emit, .is_missing, .is_infinite, .column_done,
  .column_count, .correlation
);

@@ tb/sv/testbench.sv @@
// Self-checking bench for the Pearson correlation unit: directed cells, then
// random cells under several register settings, checked by an internal predictor.
// Depends on pnsf_pkg and pearson_normalize_sparse_filter_unit.
`timescale 1ns / 100ps

module testbench;
  import pnsf_pkg::*;

  typedef struct {
    logic [15:0]        idx;
    logic signed [47:0] cp;
    logic signed [31:0] mx;
    logic [31:0]        sx;
    logic signed [31:0] my;
    logic [31:0]        sy;
    logic               last;
  } cell_t;

  typedef struct {
    logic [15:0]        row;
    logic signed [17:0] corr;
    logic               emit;
    logic               miss;
    logic               inf;
    logic               done;
    logic [16:0]        count;
  } corr_t;

  // Directed row: the typed fields replace the predicted value when known is set.
  typedef struct {
    cell_t              c;
    logic               known;
    logic signed [17:0] corr;
    logic               miss;
    logic               inf;
  } row_t;

  typedef struct {
    logic [23:0] n;
    logic        kneg;
    logic        cmiss;
    logic        cinf;
    logic [16:0] minmag;
  } setting_t;

  localparam int PhaseItems = 215;
  localparam int SettleCycles = 30;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic push, full, empty, pop;
  logic [15:0] source_index;
  logic signed [47:0] cross_prod;
  logic signed [31:0] source_mean, dest_mean;
  logic [31:0] source_sd, dest_sd;
  logic column_last;
  logic [15:0] row_out;
  logic signed [17:0] correlation;
  logic emit, is_missing, is_infinite, column_done;
  logic [16:0] column_count;

  pearson_normalize_sparse_filter_unit DUT (.*);

  // Predictor copy of the registers and the column counter.
  logic [23:0] obs_n;
  logic        keep_neg, clr_miss, clr_inf;
  logic [16:0] min_mag;
  logic [16:0] col_emits;

  corr_t expected_q[$];
  int errors;
  int received;
  bit sending_done;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("pearson_normalize_sparse_filter_unit test failed");
    $finish;
  end

  function automatic corr_t correlate(cell_t c);
    logic signed [127:0] num;
    logic [127:0] mag, den, n;
    logic neg, miss, inf;
    int q, val;
    corr_t r;
    n = (obs_n < 2) ? 128'd2 : 128'(obs_n);
    num = (128'(c.cp) <<< 16) - 128'(c.mx) * 128'(c.my) * $signed(n);
    neg = num[127];
    mag = neg ? -num : num;
    den = 128'(c.sx) * 128'(c.sy) * (n - 1);
    miss = 0;
    inf = 0;
    q = 0;
    if (den == 0) begin
      if (mag == 0) miss = 1;
      else begin
        inf = 1;
        q = 65536;
      end
    end else if (mag >= den) begin
      q = 65536;
    end else begin
      q = int'((mag << 16) / den);
    end
    val = neg ? -q : q;
    if (miss) val = 0;
    if (clr_miss && miss) miss = 0;
    if (clr_inf && inf) begin
      val = 0;
      inf = 0;
    end
    if (!keep_neg && !miss && val < 0) begin
      val = 0;
      inf = 0;
    end
    if (min_mag != 0 && !miss && ((val < 0) ? -val : val) < min_mag) begin
      val = 0;
      inf = 0;
    end
    r.emit = miss || val != 0;
    if (r.emit && col_emits < MaxSources) col_emits++;
    r.row = c.idx;
    r.corr = 18'(val);
    r.miss = miss;
    r.inf = inf;
    r.done = c.last;
    r.count = c.last ? col_emits : '0;
    if (c.last) col_emits = 0;
    return r;
  endfunction

  // Mostly cells whose cross product gives a correlation near the full range.
  function automatic cell_t random_cell();
    cell_t c;
    logic signed [127:0] t, den;
    logic [127:0] n;
    int kind, rr;
    kind = $urandom_range(0, 9);
    c.idx = 16'($urandom);
    c.last = ($urandom_range(0, 7) == 0);
    if (kind < 2) begin
      c.cp = {16'($urandom), 32'($urandom)};
      c.mx = $urandom;
      c.my = $urandom;
      c.sx = $urandom;
      c.sy = $urandom;
      return c;
    end
    n = (obs_n < 2) ? 128'd2 : 128'(obs_n);
    c.mx = $urandom_range(0, 1 << 21) - (1 << 20);
    c.my = $urandom_range(0, 1 << 21) - (1 << 20);
    c.sx = $urandom_range(1, 1 << 20);
    c.sy = $urandom_range(1, 1 << 20);
    if (kind == 2) c.sx = 0;
    if (kind == 3) c.sy = 0;
    rr = $urandom_range(0, 160000) - 80000;
    den = 128'(c.sx) * 128'(c.sy) * $signed(n - 1);
    t = $signed(n) * 128'(c.mx) * 128'(c.my) + ((128'(rr) * den) >>> 16);
    c.cp = 48'(t >>> 16);
    if (kind == 4) c.cp = 0;
    return c;
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    reg_write(RegObs, 32'(s.n));
    reg_write(RegKeepNeg, 32'(s.kneg));
    reg_write(RegClrMiss, 32'(s.cmiss));
    reg_write(RegClrInf, 32'(s.cinf));
    reg_write(RegMinMag, 32'(s.minmag));
    obs_n = s.n;
    keep_neg = s.kneg;
    clr_miss = s.cmiss;
    clr_inf = s.cinf;
    min_mag = s.minmag;
  endtask

  // Offers one request, holds it until accepted, and predicts its result.
  task automatic send_cell(input cell_t c, input row_t d, input bit typed);
    int gap;
    corr_t r;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    source_index <= c.idx;
    cross_prod <= c.cp;
    source_mean <= c.mx;
    source_sd <= c.sx;
    dest_mean <= c.my;
    dest_sd <= c.sy;
    column_last <= c.last;
    do @(posedge clk); while (full);
    r = correlate(c);
    if (typed && d.known) begin
      r.corr = d.corr;
      r.miss = d.miss;
      r.inf = d.inf;
      r.emit = d.miss || d.corr != 0;
    end
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic wait_idle();
    push <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  row_t directed[] = '{
    '{'{16'd0, 48'sd0, 32'sd0, 32'd0, 32'sd0, 32'd0, 1'b0}, 1'b1, 18'sd0, 1'b1, 1'b0},
    '{'{16'd1, 48'sd1, 32'sd0, 32'd0, 32'sd0, 32'd5, 1'b0}, 1'b1, 18'sd65536, 1'b0, 1'b1},
    '{'{16'd2, -48'sd1, 32'sd0, 32'd7, 32'sd0, 32'd0, 1'b0}, 1'b1, -18'sd65536, 1'b0, 1'b1},
    '{'{16'd3, 48'sd65536, 32'sd0, 32'd65536, 32'sd0, 32'd65536, 1'b0},
      1'b1, 18'sd65536, 1'b0, 1'b0},
    '{'{16'd4, 48'sd32768, 32'sd0, 32'd65536, 32'sd0, 32'd65536, 1'b0},
      1'b1, 18'sd32768, 1'b0, 1'b0},
    '{'{16'd5, -48'sd32768, 32'sd0, 32'd65536, 32'sd0, 32'd65536, 1'b0},
      1'b1, -18'sd32768, 1'b0, 1'b0},
    '{'{16'd6, -48'sd65536, 32'sd0, 32'd65536, 32'sd0, 32'd65536, 1'b1},
      1'b1, -18'sd65536, 1'b0, 1'b0},
    '{'{16'hFFFF, 48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
        32'hFFFF_FFFF, 1'b0}, 1'b0, 18'sd0, 1'b0, 1'b0},
    '{'{16'hFFFF, 48'h8000_0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
        32'hFFFF_FFFF, 1'b0}, 1'b0, 18'sd0, 1'b0, 1'b0},
    '{'{16'h8000, 48'sd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'hFFFF_FFFF, 1'b0}, 1'b0, 18'sd0, 1'b0, 1'b0},
    '{'{16'd9, 48'sd0, 32'sd65536, 32'd65536, -32'sd65536, 32'd0, 1'b0},
      1'b0, 18'sd0, 1'b0, 1'b0},
    '{'{16'd10, 48'sd100, 32'sd3, 32'd1, 32'sd4, 32'd1, 1'b0}, 1'b0, 18'sd0, 1'b0, 1'b0},
    '{'{16'd11, 48'sd0, 32'sd0, 32'd0, 32'sd0, 32'd0, 1'b1}, 1'b1, 18'sd0, 1'b1, 1'b0},
    '{'{16'd12, 48'sd0, 32'sd0, 32'd9, 32'sd0, 32'd9, 1'b1}, 1'b1, 18'sd0, 1'b0, 1'b0}
  };

  // Settings cover both ends of every register, including counts below two
  // and a threshold above one.
  setting_t settings[] = '{
    '{24'd0, 1'b0, 1'b1, 1'b1, 17'd0},
    '{24'd1, 1'b1, 1'b1, 1'b0, 17'd6554},
    '{24'd16777215, 1'b1, 1'b0, 1'b1, 17'd65536},
    '{24'd100, 1'b0, 1'b0, 1'b0, 17'd131071},
    '{24'd16777215, 1'b0, 1'b1, 1'b1, 17'd1},
    '{24'd37, 1'b1, 1'b0, 1'b0, 17'd32768},
    '{24'd2, 1'b1, 1'b0, 1'b0, 17'd0}
  };

  initial begin
    cell_t c;
    row_t none;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    push = 0;
    source_index = 0;
    cross_prod = 0;
    source_mean = 0;
    source_sd = 0;
    dest_mean = 0;
    dest_sd = 0;
    column_last = 0;
    obs_n = 2;
    keep_neg = 1;
    clr_miss = 0;
    clr_inf = 0;
    min_mag = 0;
    col_emits = 0;
    sending_done = 0;
    none = '{'{16'd0, 48'sd0, 32'sd0, 32'd0, 32'sd0, 32'd0, 1'b0}, 1'b0, 18'sd0, 1'b0, 1'b0};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Register defaults after reset.
    foreach (directed[i]) send_cell(directed[i].c, directed[i], 1'b1);
    repeat (PhaseItems) send_cell(random_cell(), none, 1'b0);
    foreach (settings[p]) begin
      wait_idle();
      apply_setting(settings[p]);
      repeat (PhaseItems) send_cell(random_cell(), none, 1'b0);
    end
    push <= 0;
    sending_done = 1;
  end

  // Result side: random stalls, plus one long hold-off that fills the queue.
  initial begin
    int stall;
    bit held;
    pop = 0;
    held = 0;
    @(negedge rst);
    forever begin
      if (!held && received == 400) begin
        held = 1;
        pop <= 0;
        repeat (300) @(posedge clk);
      end
      stall = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        pop <= 0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1;
      do @(posedge clk); while (empty);
    end
  end

  always @(posedge clk) begin
    corr_t e;
    if (!rst && pop && !empty) begin
      received <= received + 1;
      if (expected_q.size() == 0) begin
        $error("result for row %0d with no request outstanding", row_out);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (row_out !== e.row) begin
          $error("row_out: expected %0d, got %0d", e.row, row_out);
          errors++;
        end
        if (correlation !== e.corr) begin
          $error("correlation: expected %0d, got %0d", e.corr, correlation);
          errors++;
        end
        if (emit !== e.emit) begin
          $error("emit: expected %0b, got %0b", e.emit, emit);
          errors++;
        end
        if (is_missing !== e.miss) begin
          $error("is_missing: expected %0b, got %0b", e.miss, is_missing);
          errors++;
        end
        if (is_infinite !== e.inf) begin
          $error("is_infinite: expected %0b, got %0b", e.inf, is_infinite);
          errors++;
        end
        if (column_done !== e.done) begin
          $error("column_done: expected %0b, got %0b", e.done, column_done);
          errors++;
        end
        if (column_count !== e.count) begin
          $error("column_count: expected %0d, got %0d", e.count, column_count);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("pearson_normalize_sparse_filter_unit test passed");
    end else begin
      $display("pearson_normalize_sparse_filter_unit test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pnsf_pkg.sv
rtl/pnsf_front.sv
rtl/pnsf_queue.sv
rtl/pnsf_back.sv
rtl/pearson_normalize_sparse_filter_unit.sv
rtl/pnsf_checker.sv
tb/sv/testbench.sv
